// ----- hdl/tlpq_pkg.sv -----
`default_nettype none

package tlpq_pkg;

   localparam int FUNC_W = 2;
   localparam int STAT_W = 2;
   localparam int CNT_W  = 5;

   localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLOSE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] STAT_CLOSED = 2'd2;
   localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              out_high;
      logic              evicted;
      logic              sendable;
      logic              recvable;
      logic [CNT_W-1:0]  occupancy;
   } info_type;

endpackage

`default_nettype wire

// ----- hdl/tlpq_if.sv -----
`default_nettype none

interface tlpq_req_if #(parameter int DATA_W = 32);
   logic                          valid;
   logic                          ready;
   logic [tlpq_pkg::FUNC_W-1:0]   func;
   logic                          high_priority;
   logic [DATA_W-1:0]             payload;

   modport source (output valid, func, high_priority, payload, input ready);
   modport sink   (input valid, func, high_priority, payload, output ready);
endinterface

interface tlpq_rsp_if #(parameter int DATA_W = 32);
   logic                          valid;
   logic                          ready;
   logic [tlpq_pkg::STAT_W-1:0]   status;
   logic [DATA_W-1:0]             out_data;
   logic                          out_high;
   logic                          evicted;
   logic                          sendable;
   logic                          recvable;
   logic [tlpq_pkg::CNT_W-1:0]    occupancy;

   modport source (output valid, status, out_data, out_high, evicted, sendable, recvable,
                   occupancy, input ready);
   modport sink   (input valid, status, out_data, out_high, evicted, sendable, recvable,
                   occupancy, output ready);
endinterface

`default_nettype wire

// ----- hdl/two_level_priority_queue_evict_unit.sv -----
// Two-level priority message queue with eviction.
// The req channel carries one word per access: func selects put, get or
// close, high_priority picks the ring for a put and payload is the data.
// The rsp channel returns exactly one word per access with the status, the
// data of a successful get, the eviction flag and the occupancy flags.
// The csr port writes the shared capacity; the user must write it only
// while idle, which the block does not enforce. Each ring lives in a
// synchronous memory with one read and one write port. An accepted access
// updates pointers and counts and issues the ring reads at the same edge;
// the read data is registered there and the response word is built from
// it once the response register is free. A new access is accepted only
// after the response of the last one has been loaded.
// The response register is separate, so the next access is accepted while
// a response still waits; a stalled receiver holds that word and, after
// one more access, blocks req until the response is taken.
// Reset empties and reopens the queue and sets the capacity to 16; the
// memory contents are not cleared, since an entry is read only after it
// was written.
`default_nettype none

module two_level_priority_queue_evict_unit #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   tlpq_req_if.sink                        req,
   tlpq_rsp_if.source                      rsp,
   input  wire logic                       csr_we,
   input  wire logic [tlpq_pkg::CNT_W-1:0] csr_wdata
);
   import tlpq_pkg::*;

   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CapLim = (DEPTH > 31) ? 31 : DEPTH;

   logic [DATA_W-1:0] high_mem   [DEPTH];
   logic [DATA_W-1:0] normal_mem [DEPTH];

   logic [AW-1:0]     high_rp_ff, high_rp_in, high_wp_ff, high_wp_in;
   logic [AW-1:0]     norm_rp_ff, norm_rp_in, norm_wp_ff, norm_wp_in;
   logic [CNT_W-1:0]  high_cnt_ff, high_cnt_in, norm_cnt_ff, norm_cnt_in;
   logic              closed_ff, closed_in;
   logic [CNT_W-1:0]  cap_ff;
   state_type         state_ff, state_in;
   info_type          pend_ff, pend_in;
   logic              pend_get_ff, pend_get_in;
   logic [DATA_W-1:0] high_rd_ff, norm_rd_ff;
   logic              rsp_valid_ff;
   info_type          rsp_info_ff;
   logic [DATA_W-1:0] rsp_data_ff;

   logic              accept, load_rsp;
   logic [CNT_W-1:0]  eff_cap, total, total_after;
   logic              room, do_evict;
   logic              push_h, push_n, pop_h, pop_n, do_close;

   function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
      advance = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign accept  = req.valid && req.ready;
   assign eff_cap = (cap_ff > CNT_W'(CapLim)) ? CNT_W'(CapLim) : cap_ff;
   assign total   = high_cnt_ff + norm_cnt_ff;
   assign room    = total < eff_cap;

   always_comb begin
      pend_in.status   = STAT_OK;
      pend_in.out_high = 1'b0;
      pend_in.evicted  = 1'b0;
      pend_get_in      = 1'b0;
      do_evict         = 1'b0;
      push_h           = 1'b0;
      push_n           = 1'b0;
      pop_h            = 1'b0;
      pop_n            = 1'b0;
      do_close         = 1'b0;
      unique case (req.func)
         FUNC_PUT: begin
            if (closed_ff) begin
               pend_in.status = STAT_CLOSED;
            end else begin
               do_evict = !room && req.high_priority && (norm_cnt_ff != '0);
               if (!room && !do_evict) begin
                  pend_in.status = STAT_FULL;
               end else begin
                  push_h          = req.high_priority;
                  push_n          = !req.high_priority;
                  pop_n           = do_evict;
                  pend_in.evicted = do_evict;
               end
            end
         end
         FUNC_GET: begin
            if (closed_ff) begin
               pend_in.status = STAT_CLOSED;
            end else if (high_cnt_ff != '0) begin
               pop_h            = 1'b1;
               pend_in.out_high = 1'b1;
               pend_get_in      = 1'b1;
            end else if (norm_cnt_ff != '0) begin
               pop_n       = 1'b1;
               pend_get_in = 1'b1;
            end else begin
               pend_in.status = STAT_EMPTY;
            end
         end
         FUNC_CLOSE: begin
            do_close = 1'b1;
         end
         default: begin
         end
      endcase

      high_rp_in  = high_rp_ff;
      high_wp_in  = high_wp_ff;
      norm_rp_in  = norm_rp_ff;
      norm_wp_in  = norm_wp_ff;
      high_cnt_in = high_cnt_ff;
      norm_cnt_in = norm_cnt_ff;
      closed_in   = closed_ff;
      if (do_close) begin
         closed_in   = 1'b1;
         high_rp_in  = high_wp_ff;
         norm_rp_in  = norm_wp_ff;
         high_cnt_in = '0;
         norm_cnt_in = '0;
      end else begin
         if (push_h) begin
            high_wp_in  = advance(high_wp_ff);
            high_cnt_in = high_cnt_ff + 1'b1;
         end
         if (pop_h) begin
            high_rp_in  = advance(high_rp_ff);
            high_cnt_in = high_cnt_ff - 1'b1;
         end
         if (push_n && !pop_n) begin
            norm_wp_in  = advance(norm_wp_ff);
            norm_cnt_in = norm_cnt_ff + 1'b1;
         end
         if (pop_n) begin
            norm_rp_in  = advance(norm_rp_ff);
            norm_cnt_in = norm_cnt_ff - 1'b1;
         end
      end

      total_after       = high_cnt_in + norm_cnt_in;
      pend_in.sendable  = total_after < eff_cap;
      pend_in.recvable  = total_after != '0;
      pend_in.occupancy = total_after;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      load_rsp  = (state_ff == ST_WAIT) && (!rsp_valid_ff || rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         high_rp_ff   <= '0;
         high_wp_ff   <= '0;
         norm_rp_ff   <= '0;
         norm_wp_ff   <= '0;
         high_cnt_ff  <= '0;
         norm_cnt_ff  <= '0;
         closed_ff    <= 1'b0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (accept) begin
            high_rp_ff  <= high_rp_in;
            high_wp_ff  <= high_wp_in;
            norm_rp_ff  <= norm_rp_in;
            norm_wp_ff  <= norm_wp_in;
            high_cnt_ff <= high_cnt_in;
            norm_cnt_ff <= norm_cnt_in;
            closed_ff   <= closed_in;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff     <= pend_in;
         pend_get_ff <= pend_get_in;
      end
      if (load_rsp) begin
         rsp_info_ff <= pend_ff;
         if (!pend_get_ff) begin
            rsp_data_ff <= '0;
         end else if (pend_ff.out_high) begin
            rsp_data_ff <= high_rd_ff;
         end else begin
            rsp_data_ff <= norm_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         high_rd_ff <= high_mem[high_rp_ff];
      end
      if (accept && push_h) begin
         high_mem[high_wp_ff] <= req.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         norm_rd_ff <= normal_mem[norm_rp_ff];
      end
      if (accept && push_n) begin
         normal_mem[norm_wp_ff] <= req.payload;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_info_ff.status;
   assign rsp.out_data  = rsp_data_ff;
   assign rsp.out_high  = rsp_info_ff.out_high;
   assign rsp.evicted   = rsp_info_ff.evicted;
   assign rsp.sendable  = rsp_info_ff.sendable;
   assign rsp.recvable  = rsp_info_ff.recvable;
   assign rsp.occupancy = rsp_info_ff.occupancy;

   a_closed_empty: assert property (@(posedge clock) disable iff (reset)
      closed_ff |-> (high_cnt_ff == '0) && (norm_cnt_ff == '0))
      else $error("closed queue holds entries");

   a_accept_wait: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_WAIT))
      else $error("accepted access did not enter the read wait");

   a_evict_put: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.evicted) |-> (rsp.status == STAT_OK) && !rsp.out_high
                                     && (rsp.out_data == '0))
      else $error("eviction reported on a failed put or a get");

   a_empty_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == STAT_EMPTY) |-> !rsp.recvable && (rsp.occupancy == '0))
      else $error("empty get reports buffered entries");

endmodule

`default_nettype wire
